// ----- sv/task_fault_restart_supervisor_core_defines.svh -----
// Assertion macros shared by the supervisor RTL
`ifndef TASK_FAULT_RESTART_SUPERVISOR_CORE_DEFINES_SVH
`define TASK_FAULT_RESTART_SUPERVISOR_CORE_DEFINES_SVH
// Implication checked on every rising clock edge, off during reset
`define TFRS_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent
`define TFRS_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- sv/tfrs_pkg.sv -----
// ----------------------------------------------------------------------------
// tfrs_pkg
// Types and codes shared by the task fault restart supervisor modules.
// ----------------------------------------------------------------------------
package tfrs_pkg;

    // Table size and task id width; the beat fields are sized for these
    localparam int SLOTS        = 8;
    localparam int TASK_ID_BITS = 16;

    typedef enum logic [2:0] {
        OP_REGISTER = 3'd0,
        OP_FAULT    = 3'd1,
        OP_KILL     = 3'd2,
        OP_POLL     = 3'd3,
        OP_SPAWN    = 3'd4
    } op_code_t;

    typedef enum logic [3:0] {
        K_NONE      = 4'd0,
        K_REGISTERED = 4'd1,
        K_FULL      = 4'd2,
        K_ISOLATED  = 4'd3,
        K_REFUSED   = 4'd4,
        K_KILLED    = 4'd5,
        K_RESPAWN   = 4'd6,
        K_GIVEN_UP  = 4'd7,
        K_RESPAWNED = 4'd8,
        K_SPAWN_FAIL = 4'd9
    } kind_t;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_RUNNING = 2'd1,
        ST_DEAD    = 2'd2,
        ST_ABANDONED = 2'd3
    } slot_st_t;

    typedef enum logic [1:0] {
        EX_IDLE = 2'd0,
        EX_SCAN = 2'd1,
        EX_EMIT = 2'd2
    } ex_state_t;

    localparam logic [31:0] ADDR_BACKOFF = 32'd0;
    localparam logic [31:0] ADDR_LIMIT   = 32'd1;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  slot_index;
        logic [15:0] task_id;
        logic        spawn_ok;
        logic        context_ok;
        logic        has_recovery;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  slot_out;
        logic [15:0] task_id_out;
        logic [7:0]  death_count_out;
        logic        run_recovery;
        logic        last;
    } out_item_t;

    // Beat from the front end to the execution unit
    typedef struct packed {
        logic      is_poll;
        in_item_t  item;
    } cmd_t;

endpackage

// ----- sv/tfrs_front.sv -----
// ----------------------------------------------------------------------------
// tfrs_front
// Input stage and command queue: takes input beats, flags polls, and holds
// a short queue of commands for the execution unit.
// ----------------------------------------------------------------------------
module tfrs_front #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tfrs_pkg::in_item_t  in_data,
    output logic                cmd_valid,
    input  logic                cmd_take,
    output tfrs_pkg::cmd_t      cmd_data
);
    import tfrs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t            q_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]     count_reg;
    logic            push, pop;

    assign in_stall  = (count_reg == (AW+1)'(DEPTH));
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_take && cmd_valid;
    assign cmd_data  = q_reg[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].item    <= in_data;
            q_reg[wr_ptr_reg].is_poll <= (in_data.op == OP_POLL);
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    `include "task_fault_restart_supervisor_core_defines.svh"
    `TFRS_ASSERT_IMP(a_no_overflow, count_reg == (AW+1)'(DEPTH), !push)
    `TFRS_ASSERT_NEXT(a_pop_count, pop && !push, count_reg == $past(count_reg) - 1'b1)
    `TFRS_ASSERT_IMP(a_count_range, 1'b1, count_reg <= (AW+1)'(DEPTH))
endmodule

// ----- sv/tfrs_exec.sv -----
// ----------------------------------------------------------------------------
// tfrs_exec
// Execution unit: holds the slot table, carries out one command at a time,
// scans slots one per cycle for a poll, pausing on a hit while the output is
// not free, and drives a one-entry result register.
// ----------------------------------------------------------------------------
module tfrs_exec (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_take,
    input  tfrs_pkg::cmd_t       cmd_data,
    input  logic [15:0]          backoff_base,
    input  logic [4:0]           death_limit,
    output logic                 out_valid,
    input  logic                 out_stall,
    output tfrs_pkg::out_item_t  out_data,
    output logic                 busy
);
    import tfrs_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    slot_st_t                 st_reg   [SLOTS];
    logic [TASK_ID_BITS-1:0]  id_reg   [SLOTS];
    logic [7:0]               dth_reg  [SLOTS];
    logic [31:0]              dtime_reg[SLOTS];
    logic                     rec_reg  [SLOTS];
    logic                     kif_reg;
    logic [SW-1:0]            dying_reg;

    ex_state_t                state_reg, state_next;
    cmd_t                     cmd_reg;
    logic [SW-1:0]            scan_reg;
    logic [3:0]               nres_reg;
    logic                     ov_reg;
    out_item_t                od_reg;
    logic                     pend_reg;   // captured poll result not yet known to be last

    // Combined lookups (small table, independent per slot)
    logic [SW-1:0] free_idx, run_idx;
    logic          free_hit, run_hit;
    logic [TASK_ID_BITS-1:0] cmd_id;
    assign cmd_id = cmd_data.item.task_id[TASK_ID_BITS-1:0];

    always_comb
    begin
        free_hit = 1'b0;
        run_hit  = 1'b0;
        free_idx = '0;
        run_idx  = '0;
        for (int i = SLOTS-1; i >= 0; i--)
        begin
            if (st_reg[i] == ST_FREE)
            begin
                free_hit = 1'b1;
                free_idx = SW'(i);
            end
            if (st_reg[i] == ST_RUNNING && id_reg[i] == cmd_id)
            begin
                run_hit = 1'b1;
                run_idx = SW'(i);
            end
        end
    end

    // Poll evaluation of the current scan slot
    logic [7:0]  sd;
    logic [7:0]  sh;
    logic [46:0] wait_ms;
    logic [31:0] elapsed;
    logic        is_dead, give_up, due;
    assign sd      = dth_reg[scan_reg];
    assign sh      = (sd == 8'd0) ? 8'd0 : sd - 8'd1;
    assign wait_ms = (sh > 8'd31) ? {47{1'b1}} : (47'(backoff_base) << sh[4:0]);
    assign elapsed = cmd_reg.item.now_ms - dtime_reg[scan_reg];
    assign is_dead = (st_reg[scan_reg] == ST_DEAD);
    assign give_up = is_dead && (sd > {3'b0, death_limit});
    assign due     = is_dead && !give_up && (47'(elapsed) >= wait_ms);

    logic out_free;
    assign out_free  = !ov_reg || !out_stall;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign busy      = (state_reg != EX_IDLE) || ov_reg;
    assign cmd_take  = (state_reg == EX_IDLE) && cmd_valid && out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            EX_IDLE: if (cmd_take && cmd_data.is_poll) state_next = EX_SCAN;
            EX_SCAN:
            begin
                // leave once the last slot is either quiet or captured
                if (scan_reg == SW'(SLOTS-1) &&
                    (!(give_up || due) || (!pend_reg && !ov_reg)))
                    state_next = EX_EMIT;
            end
            EX_EMIT: if (out_free) state_next = EX_IDLE;
            default: state_next = EX_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= EX_IDLE;
        else
            state_reg <= state_next;
    end

    // Table, output register and sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                st_reg[i]    <= ST_FREE;
                id_reg[i]    <= '0;
                dth_reg[i]   <= '0;
                dtime_reg[i] <= '0;
                rec_reg[i]   <= 1'b0;
            end
            kif_reg   <= 1'b0;
            dying_reg <= '0;
            ov_reg    <= 1'b0;
            od_reg    <= '0;
            cmd_reg   <= '0;
            scan_reg  <= '0;
            nres_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            case (state_reg)
                EX_IDLE:
                begin
                    if (cmd_take)
                    begin
                        cmd_reg <= cmd_data;
                        if (cmd_data.is_poll)
                        begin
                            scan_reg <= '0;
                            nres_reg <= '0;
                            pend_reg <= 1'b0;
                        end
                        else
                        begin
                            ov_reg <= 1'b1;
                            od_reg <= '0;
                            od_reg.last <= 1'b1;
                            case (cmd_data.item.op)
                                OP_REGISTER:
                                begin
                                    od_reg.task_id_out <= 16'(cmd_id);
                                    if (free_hit)
                                    begin
                                        st_reg[free_idx]    <= ST_RUNNING;
                                        id_reg[free_idx]    <= cmd_id;
                                        dth_reg[free_idx]   <= '0;
                                        dtime_reg[free_idx] <= '0;
                                        rec_reg[free_idx]   <= cmd_data.item.has_recovery;
                                        od_reg.kind     <= K_REGISTERED;
                                        od_reg.slot_out <= 3'(free_idx);
                                    end
                                    else
                                        od_reg.kind <= K_FULL;
                                end
                                OP_FAULT:
                                begin
                                    od_reg.task_id_out <= 16'(cmd_id);
                                    if (!kif_reg && cmd_data.item.context_ok && run_hit)
                                    begin
                                        kif_reg   <= 1'b1;
                                        dying_reg <= run_idx;
                                        od_reg.kind <= K_ISOLATED;
                                        od_reg.slot_out <= 3'(run_idx);
                                        od_reg.death_count_out <= dth_reg[run_idx];
                                    end
                                    else
                                        od_reg.kind <= K_REFUSED;
                                end
                                OP_KILL:
                                begin
                                    kif_reg <= 1'b0;
                                    if (kif_reg)
                                    begin
                                        st_reg[dying_reg]    <= ST_DEAD;
                                        id_reg[dying_reg]    <= '0;
                                        dtime_reg[dying_reg] <= cmd_data.item.now_ms;
                                        if (dth_reg[dying_reg] != 8'hFF)
                                            dth_reg[dying_reg] <= dth_reg[dying_reg] + 8'd1;
                                        od_reg.kind <= K_KILLED;
                                        od_reg.slot_out <= 3'(dying_reg);
                                        od_reg.task_id_out <= 16'(id_reg[dying_reg]);
                                        od_reg.death_count_out <=
                                            (dth_reg[dying_reg] != 8'hFF) ?
                                            dth_reg[dying_reg] + 8'd1 : 8'hFF;
                                    end
                                end
                                OP_SPAWN:
                                begin
                                    od_reg.slot_out <= cmd_data.item.slot_index;
                                    if ({1'b0, cmd_data.item.slot_index} < 4'(SLOTS) &&
                                        st_reg[SW'(cmd_data.item.slot_index)] == ST_DEAD)
                                    begin
                                        od_reg.death_count_out <=
                                            dth_reg[SW'(cmd_data.item.slot_index)];
                                        if (cmd_data.item.spawn_ok)
                                        begin
                                            id_reg[SW'(cmd_data.item.slot_index)] <= cmd_id;
                                            st_reg[SW'(cmd_data.item.slot_index)] <= ST_RUNNING;
                                            od_reg.kind <= K_RESPAWNED;
                                            od_reg.task_id_out <= 16'(cmd_id);
                                        end
                                        else
                                        begin
                                            dtime_reg[SW'(cmd_data.item.slot_index)] <=
                                                cmd_data.item.now_ms;
                                            od_reg.kind <= K_SPAWN_FAIL;
                                            od_reg.task_id_out <=
                                                16'(id_reg[SW'(cmd_data.item.slot_index)]);
                                        end
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                EX_SCAN:
                begin
                    // one slot per cycle; a hit waits until the output frees
                    if (give_up || due)
                    begin
                        if (pend_reg)
                        begin
                            // earlier hit is not last: release it, output is empty here
                            ov_reg <= 1'b1;
                            pend_reg <= 1'b0;
                        end
                        else if (!ov_reg)
                        begin
                            // hold the result until we know whether it is last
                            pend_reg <= 1'b1;
                            od_reg <= '0;
                            od_reg.kind <= give_up ? K_GIVEN_UP : K_RESPAWN;
                            od_reg.slot_out <= 3'(scan_reg);
                            od_reg.task_id_out <= 16'(id_reg[scan_reg]);
                            od_reg.death_count_out <= sd;
                            od_reg.run_recovery <= due && rec_reg[scan_reg];
                            if (give_up)
                                st_reg[scan_reg] <= ST_ABANDONED;
                            nres_reg <= nres_reg + 4'd1;
                            if (scan_reg != SW'(SLOTS-1))
                                scan_reg <= scan_reg + 1'b1;
                        end
                    end
                    else if (scan_reg != SW'(SLOTS-1))
                        scan_reg <= scan_reg + 1'b1;
                end
                EX_EMIT:
                begin
                    if (out_free)
                    begin
                        ov_reg <= 1'b1;
                        if (!pend_reg && nres_reg == 4'd0)
                        begin
                            od_reg <= '0;
                        end
                        od_reg.last <= 1'b1;
                        pend_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    `include "task_fault_restart_supervisor_core_defines.svh"
    `TFRS_ASSERT_IMP(a_take_idle, cmd_take, state_reg == EX_IDLE)
    `TFRS_ASSERT_IMP(a_hold_stalled, ov_reg && out_stall, state_next != EX_IDLE || state_reg != EX_EMIT)
    `TFRS_ASSERT_NEXT(a_kill_clears, cmd_take && cmd_data.item.op == OP_KILL, !kif_reg)
    `TFRS_ASSERT_IMP(a_results_bound, 1'b1, nres_reg <= 4'(SLOTS))
endmodule

// ----- sv/tfrs_cfg.sv -----
// ----------------------------------------------------------------------------
// tfrs_cfg
// APB-style register file: backoff base and death limit.
// ----------------------------------------------------------------------------
module tfrs_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] backoff_base,
    output logic [4:0]  death_limit
);
    import tfrs_pkg::*;

    logic [15:0] base_reg;
    logic [4:0]  lim_reg;
    logic        wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign backoff_base = base_reg;
    assign death_limit  = lim_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 16'd200;
            lim_reg  <= 5'd8;
        end
        else if (wr)
        begin
            if (32'(paddr[2]) == ADDR_BACKOFF && paddr[1:0] == 2'b00)
                base_reg <= pwdata[15:0];
            else if (32'(paddr[2]) == ADDR_LIMIT && paddr[1:0] == 2'b00)
                lim_reg <= pwdata[4:0];
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            if (32'(paddr[2]) == ADDR_BACKOFF)
                prdata = {16'd0, base_reg};
            else
                prdata = {27'd0, lim_reg};
        end
    end
endmodule

// ----- sv/task_fault_restart_supervisor_core.sv -----
// ----------------------------------------------------------------------------
// task_fault_restart_supervisor_core
// Fault and restart supervisor for a table of guarded tasks.
// ----------------------------------------------------------------------------
// Each input beat produces one or more result beats, the last flagged.
// For register, fault, kill commit and spawn result the result beat is
// loaded into the one-entry result register of the execution unit once
// it takes the command from the queue; a poll walks the slot table one
// slot per cycle, pausing on a reported slot while the result register
// is busy or stalled, and each reported slot is a result beat of its
// own, paced by the scan sequencer in the execution unit. A two-entry
// command queue lets input beats be taken while a poll is in progress.
module task_fault_restart_supervisor_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  tfrs_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output tfrs_pkg::out_item_t  out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import tfrs_pkg::*;

    logic        cmd_valid, cmd_take, busy;
    cmd_t        cmd_data;
    logic [15:0] backoff_base;
    logic [4:0]  death_limit;

    tfrs_cfg u_cfg (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .pready, .backoff_base, .death_limit
    );

    tfrs_front #(.DEPTH(2)) u_front (
        .clk, .rst_n, .in_valid, .in_stall, .in_data,
        .cmd_valid, .cmd_take, .cmd_data
    );

    tfrs_exec u_exec (
        .clk, .rst_n, .cmd_valid, .cmd_take, .cmd_data, .backoff_base,
        .death_limit, .out_valid, .out_stall, .out_data, .busy
    );

    `include "task_fault_restart_supervisor_core_defines.svh"
    `TFRS_ASSERT_IMP(a_take_needs_valid, cmd_take, cmd_valid)
    `TFRS_ASSERT_IMP(a_out_busy, out_valid, busy)
    `TFRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
endmodule
